>>> sv/b64e_pkg.sv
package b64e_pkg;

   // Pad character '='
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Bytes pending in the current group
   localparam logic [1:0] PHASE_EMPTY = 2'd0;
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;

   // Pad counts of a finished group
   localparam logic [1:0] PADS_NONE = 2'd0;
   localparam logic [1:0] PADS_ONE  = 2'd1;
   localparam logic [1:0] PADS_TWO  = 2'd2;

   // Character slots within a group
   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;
   localparam logic [1:0] SLOT_LAST   = 2'd3;

   // Finished group handed from front to back
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  pads;
      logic        last;
   } group_type;

   // Map a 6-bit index to its character of the standard alphabet
   function automatic logic [7:0] sym_char(input logic [5:0] idx);
      logic [7:0] wide;
      wide = {2'b00, idx};
      if (idx < 6'd26) begin
         return 8'h41 + wide;
      end else if (idx < 6'd52) begin
         return 8'h61 + wide - 8'd26;
      end else if (idx < 6'd62) begin
         return 8'h30 + wide - 8'd52;
      end else if (idx == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

>>> sv/b64e_front.sv
module b64e_front
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   input  logic       q_full,
   output logic       q_push,
   output group_type  q_data
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  phase_ff, phase_in;
   logic        accept;
   logic        emit;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Classify the request: store it, or close a group
   always_comb begin
      held_in  = held_ff;
      phase_in = phase_ff;
      emit     = 1'b0;
      q_data   = '{bits: {req_data_byte, 16'h0000}, pads: PADS_TWO, last: 1'b1};
      if (phase_ff == PHASE_ONE) begin
         if (!req_final_byte) begin
            held_in  = {held_ff[15:8], req_data_byte};
            phase_in = PHASE_TWO;
         end else begin
            emit   = 1'b1;
            q_data = '{bits: {held_ff[15:8], req_data_byte, 8'h00},
                       pads: PADS_ONE, last: 1'b1};
         end
      end else if (phase_ff == PHASE_TWO) begin
         emit   = 1'b1;
         q_data = '{bits: {held_ff, req_data_byte}, pads: PADS_NONE,
                    last: req_final_byte};
      end else begin
         // Empty phase and the unreachable fourth code both start a group
         if (!req_final_byte) begin
            held_in  = {req_data_byte, 8'h00};
            phase_in = PHASE_ONE;
         end else begin
            emit = 1'b1;
         end
      end
      if (emit) begin
         held_in  = 16'h0000;
         phase_in = PHASE_EMPTY;
      end
   end

   assign q_push = accept && emit;

   // Advance the gathering state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 16'h0000;
         phase_ff <= PHASE_EMPTY;
      end else if (accept) begin
         held_ff  <= held_in;
         phase_ff <= phase_in;
      end
   end

endmodule

>>> sv/b64e_queue.sv
module b64e_queue
   import b64e_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output group_type pop_data
);

   group_type  slots [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slots[rd_ptr_ff];

   // Next pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");

endmodule

>>> sv/b64e_back.sv
module b64e_back
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  group_type  q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_msg_end
);

   group_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] slot_ff, slot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       end_ff, end_in;
   logic       out_free;
   logic       emit;
   logic       done;
   logic [5:0] idx;
   logic       pad;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = cur_valid_ff && out_free;
   assign done     = emit && (slot_ff == SLOT_LAST);
   assign q_pop    = q_not_empty && (!cur_valid_ff || done);

   // Pick the 6-bit group of the current slot, most significant first
   always_comb begin
      unique case (slot_ff)
         SLOT_FIRST:  idx = cur_ff.bits[23:18];
         SLOT_SECOND: idx = cur_ff.bits[17:12];
         SLOT_THIRD:  idx = cur_ff.bits[11:6];
         SLOT_LAST:   idx = cur_ff.bits[5:0];
      endcase
   end

   // Trailing slots become pad characters
   assign pad = ((cur_ff.pads == PADS_TWO) && (slot_ff >= SLOT_THIRD)) ||
                ((cur_ff.pads == PADS_ONE) && (slot_ff == SLOT_LAST));

   // Next values of the group holder and output register
   always_comb begin
      cur_in       = q_pop ? q_data : cur_ff;
      cur_valid_in = q_pop ? 1'b1 : (done ? 1'b0 : cur_valid_ff);
      slot_in      = q_pop ? SLOT_FIRST : (emit ? slot_ff + 2'd1 : slot_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      char_in      = emit ? (pad ? PAD_CHAR : sym_char(idx)) : char_ff;
      end_in       = emit ? (cur_ff.last && (slot_ff == SLOT_LAST)) : end_ff;
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         slot_ff      <= SLOT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      char_ff <= char_in;
      end_ff  <= end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_msg_end  = end_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_char)))
      else $error("stalled response changed");
   assert property (@(posedge clock) disable iff (reset)
      (emit && slot_ff != SLOT_LAST) |=> !rsp_msg_end)
      else $error("message end before last slot");
   assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && !done) |-> !q_pop)
      else $error("group replaced before it finished");

endmodule

>>> sv/base64_stream_encoder.sv
// Streaming Base64 encoder, standard alphabet with '=' padding.
//
// Request channel: one message byte per request on req_data_byte, with
// req_final_byte high on the last byte of a message. Response channel: one
// ASCII character per response on rsp_out_char, rsp_msg_end high on the
// last character of each message. Both use valid/ready.
//
// The front gathers bytes; each third byte, or a final byte, closes a group
// that goes into a two-entry queue. The back turns each group into four
// characters, one per cycle while the receiver is ready, through a
// registered output stage. rsp_valid for the first character of a group
// rises once the group has passed the queue entry, the group holder and the
// output register. Throughput is one character per cycle while rsp_ready
// holds, set by the single output register, so full groups sustain three
// requests for every four characters.
//
// Reset clears the pending bytes, the queue and the output register.
// When the receiver stalls, the output holds its character, the back stops,
// the queue fills, and req_ready drops once both queue entries are taken.
module base64_stream_encoder
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_msg_end
);

   group_type push_data;
   group_type pop_data;
   logic      push;
   logic      full;
   logic      pop;
   logic      not_empty;

   b64e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (full),
      .q_push         (push),
      .q_data         (push_data)
   );

   b64e_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_not_empty  (not_empty),
      .q_data       (pop_data),
      .q_pop        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_msg_end  (rsp_msg_end)
   );

endmodule

>>> bench/base64_stream_encoder_tb.sv
module base64_stream_encoder_tb
   import b64e_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RANDOM_ITEMS     = 80;

   // Tracks the pending group and the characters still owed by the encoder
   class b64_char_checker;
      typedef struct {
         logic [7:0] ch;
         logic       last;
      } char_due_type;

      char_due_type chars_due[$];
      logic [15:0]  pend_bytes;
      logic [1:0]   pend_count;
      int           errors;
      string        alphabet;

      function new();
         pend_bytes = '0;
         pend_count = PHASE_EMPTY;
         errors     = 0;
         alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      // Cut a 24-bit group into four characters, trailing ones replaced by pads
      task queue_group(logic [23:0] bits, logic [1:0] pads, logic last);
         char_due_type due;
         logic [5:0] idx;
         for (int k = 0; k < 4; k++) begin
            idx = bits[18 - 6 * k +: 6];
            due.ch = (k >= 4 - int'(pads)) ? PAD_CHAR : alphabet[idx];
            due.last = last && (k == 3);
            chars_due.push_back(due);
         end
      endtask

      // Fold one accepted request into the pending group
      task note_request(logic [7:0] data, logic fin);
         unique case (pend_count)
            PHASE_ONE: begin
               if (!fin) begin
                  pend_bytes[7:0] = data;
                  pend_count = PHASE_TWO;
               end else begin
                  queue_group({pend_bytes[15:8], data, 8'h00}, PADS_ONE, 1'b1);
                  pend_bytes = '0;
                  pend_count = PHASE_EMPTY;
               end
            end
            PHASE_TWO: begin
               queue_group({pend_bytes, data}, PADS_NONE, fin);
               pend_bytes = '0;
               pend_count = PHASE_EMPTY;
            end
            default: begin
               if (!fin) begin
                  pend_bytes = {data, 8'h00};
                  pend_count = PHASE_ONE;
               end else begin
                  queue_group({data, 16'h0000}, PADS_TWO, 1'b1);
                  pend_bytes = '0;
                  pend_count = PHASE_EMPTY;
               end
            end
         endcase
      endtask

      // Compare one accepted character against the oldest one owed
      task check_response(logic [7:0] ch, logic last);
         char_due_type due;
         if (chars_due.size() == 0) begin
            report($sformatf("unexpected character 0x%02h end=%0b", ch, last));
         end else begin
            due = chars_due.pop_front();
            if (ch !== due.ch)
               report($sformatf("char 0x%02h, want 0x%02h", ch, due.ch));
            if (last !== due.last)
               report($sformatf("msg_end %0b, want %0b", last, due.last));
         end
      endtask

      function bit drained();
         return chars_due.size() == 0;
      endfunction

      task check_leftover();
         if (chars_due.size() != 0)
            report($sformatf("%0d characters never arrived", chars_due.size()));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_msg_end;

   b64_char_checker sb = new();

   bit sender_quiet   = 1'b1;
   bit receiver_quiet = 1'b1;
   bit hold_request   = 1'b0;
   bit hold_active    = 1'b0;
   int random_sent    = 0;

   base64_stream_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_char   (rsp_out_char),
      .rsp_msg_end    (rsp_msg_end)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Watch both channels and feed the checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_data_byte, req_final_byte);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_out_char, rsp_msg_end);
      end
   end

   // Receiver: random stalls, or one long hold-off on request
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
            rsp_ready <= 1'b1;
         end else if (receiver_quiet || $urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (idle_length() - 1) @(posedge clock);
         end
      end
   end

   // Offer one byte and hold it until accepted
   task send_request(logic [7:0] data, logic fin);
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_final_byte <= fin;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Drop valid for a random gap, unless the sender is in a quiet stretch
   task idle_sender();
      int gap;
      gap = (sender_quiet || $urandom_range(0, 99) < 50) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task send_byte(logic [7:0] data, logic fin);
      send_request(data, fin);
      idle_sender();
   endtask

   task send_text(string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], i == s.len() - 1);
   endtask

   // Random message content, last byte flagged final
   task send_message(int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
         random_sent++;
      end
   endtask

   task wait_drained();
      while (!sb.drained()) @(posedge clock);
   endtask

   initial begin
      int len;
      int drain_cycles;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one, two and three byte tails at the byte extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // Full group not final, then a single-byte tail
      send_text("ManM");
      // Final byte landing on a complete group
      send_text("foobar");
      send_text("fo");

      // Long receiver hold-off while the sender keeps offering a burst
      hold_request = 1'b1;
      do @(posedge clock); while (!hold_active);
      send_message(16);

      // Sender pauses until every character has come back
      req_valid <= 1'b0;
      wait_drained();

      // Random messages: a quiet stretch first, then idling on both sides
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= 40) begin
            sender_quiet = 1'b0;
            receiver_quiet = 1'b0;
         end
         len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9) : $urandom_range(10, 24);
         send_message(len);
      end
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle before the leftover check
      drain_cycles = 0;
      while (!sb.drained() && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      sb.check_leftover();

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
